// File: src/next_fit_partition_allocator_assert.svh
// Assertion macros shared by the allocator RTL
`ifndef NEXT_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset
`define NFPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check on every clock edge, reset included
`define NFPA_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define NFPA_ASSERT(label, prop, msg)
`define NFPA_ASSERT_ANY(label, prop, msg)
`endif
`endif

// File: src/nfpa_pkg.sv
// Shared types and constants of the next-fit partition allocator
package nfpa_pkg;

    localparam int NUM_PARTS_DEF  = 8;
    localparam int MEM_TOTAL_DEF  = 2000;
    localparam int OS_RESERVE_DEF = 100;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int SIZE_W     = 12;
    localparam int SLACK_W    = 16;
    localparam int FIDX_W     = 3;
    localparam int PART_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE0_RST = 12'd100;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_MEM_FULL  = 3'd1,
        ST_EXCEEDS   = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_FREED     = 3'd4,
        ST_INVALID   = 3'd5
    } t_status;

    // Broadcast from the controller to every cell of the ring
    typedef struct packed {
        logic              load;    // place the search token at the start cell
        logic              shift;   // pass the token to the next cell
        logic              commit;  // token cell takes the request
        logic [SIZE_W-1:0] req;     // request size under search
    } t_cell_ctl;

endpackage

// File: src/nfpa_cell.sv
// One partition cell: occupancy, held size and the travelling search token
module nfpa_cell #(
    parameter logic                      P_RST_OCC  = 1'b0,
    parameter logic [nfpa_pkg::SIZE_W-1:0] P_RST_HELD = '0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nfpa_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_start,
    input  logic                          i_tok_in,
    input  logic                          i_free,
    input  logic [nfpa_pkg::SIZE_W-1:0]   i_size,
    output logic                          o_tok,
    output logic                          o_hit,
    output logic                          o_occ,
    output logic [nfpa_pkg::SIZE_W-1:0]   o_held
);

    logic                        r_tok;
    logic                        r_occ;
    logic [nfpa_pkg::SIZE_W-1:0] r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_occ  <= P_RST_OCC;
            r_held <= P_RST_HELD;
        end else begin
            if (i_ctl.load) begin
                r_tok <= i_start;
            end else if (i_ctl.shift) begin
                r_tok <= i_tok_in;
            end
            if (i_ctl.commit && r_tok) begin
                r_occ  <= 1'b1;
                r_held <= i_ctl.req;
            end else if (i_free) begin
                r_occ  <= 1'b0;
                r_held <= '0;
            end
        end
    end

    // Free partition big enough under the token
    assign o_hit  = r_tok && !r_occ && (i_size >= i_ctl.req);
    assign o_tok  = r_tok;
    assign o_occ  = r_occ;
    assign o_held = r_held;

endmodule

// File: src/next_fit_partition_allocator.sv
// Top level of the next-fit fixed-partition allocator
//
//  channel   direction  payload (low bit first)                         handshake
//  s_axis    in         tuser: operation; tdata: request_size,          tvalid/tready
//                       free_index, zero pad to 16
//  m_axis    out        tuser: status; tdata: partition, used_total,    tvalid/tready
//                       slack_total, zero pad to 32
//  cfg       in         i_cfg_index, i_cfg_data (size_part0..7)         valid/ready
//
// A free or a refused allocate passes through accept, check and hand to the
// output register. An allocate that searches passes through accept, check, a
// scan that visits at most NUM_PARTS cells, and hand to the output register;
// the token steps one cell a cycle round the ring of partition cells.
// Reset (synchronous, active low) restores partition zero as the system
// reservation, the search start at partition one and the sizes to defaults.
// One request is in flight at a time; a finished result waits in the output
// register while the next request is taken, and a stalled output holds the
// block before it loads the following result.
`include "next_fit_partition_allocator_assert.svh"

module next_fit_partition_allocator #(
    parameter int NUM_PARTS  = nfpa_pkg::NUM_PARTS_DEF,
    parameter int MEM_TOTAL  = nfpa_pkg::MEM_TOTAL_DEF,
    parameter int OS_RESERVE = nfpa_pkg::OS_RESERVE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [nfpa_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // request_size, free_index
    input  logic                               s_axis_tuser,  // operation
    // Results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [nfpa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // partition, used, slack
    output logic [nfpa_pkg::STATUS_W-1:0]      m_axis_tuser,  // status
    // Partition size registers
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nfpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nfpa_pkg::SIZE_W-1:0]        i_cfg_data
);

    localparam int IW = $clog2(NUM_PARTS);
    localparam int EW = IW + 3;
    localparam int SW = nfpa_pkg::SIZE_W;
    localparam int LW = nfpa_pkg::SLACK_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Configuration registers
    logic [SW-1:0] r_size [nfpa_pkg::NUM_REGS];

    // Controller state
    t_state                          r_state,      n_state;
    nfpa_pkg::t_op                   r_op,         n_op;
    logic [SW-1:0]                   r_req,        n_req;
    logic [nfpa_pkg::FIDX_W-1:0]     r_fidx,       n_fidx;
    logic [SW-1:0]                   r_used,       n_used;
    logic [LW-1:0]                   r_slack,      n_slack;
    logic [IW-1:0]                   r_start,      n_start;
    logic [IW-1:0]                   r_pos,        n_pos;
    logic [IW-1:0]                   r_cnt,        n_cnt;
    nfpa_pkg::t_status               r_res_status, n_res_status;
    logic [nfpa_pkg::PART_W-1:0]     r_res_part,   n_res_part;

    // Output register
    logic                            r_out_valid,  n_out_valid;
    nfpa_pkg::t_status               r_out_status, n_out_status;
    logic [nfpa_pkg::PART_W-1:0]     r_out_part,   n_out_part;
    logic [SW-1:0]                   r_out_used,   n_out_used;
    logic [LW-1:0]                   r_out_slack,  n_out_slack;

    // Cell ring
    nfpa_pkg::t_cell_ctl             w_ctl;
    logic                            w_release;
    logic [NUM_PARTS-1:0]            w_tok;
    logic [NUM_PARTS-1:0]            w_hit;
    logic [NUM_PARTS-1:0]            w_occ;
    logic [SW-1:0]                   w_held [NUM_PARTS];
    logic [SW-1:0]                   w_cell_size [NUM_PARTS];

    // Index helpers
    logic [EW-1:0]                   w_fidx_ext;
    logic                            w_fidx_ok;
    logic [IW-1:0]                   w_fidx_idx;
    logic [EW-1:0]                   w_pos_ext;
    logic [SW-1:0]                   w_pos_size;
    logic [SW-1:0]                   w_diff;
    logic [LW:0]                     w_slack_sum;
    logic [SW:0]                     w_used_sum;
    logic [SW-1:0]                   w_free_held;

    assign w_fidx_ext = EW'(r_fidx);
    assign w_fidx_ok  = w_fidx_ext < EW'(NUM_PARTS);
    assign w_fidx_idx = w_fidx_ext[IW-1:0];
    assign w_free_held = w_held[w_fidx_idx];

    assign w_pos_ext  = EW'(r_pos);
    assign w_pos_size = (w_pos_ext < EW'(nfpa_pkg::NUM_REGS)) ?
                        r_size[w_pos_ext[nfpa_pkg::REG_IDX_W-1:0]] : '0;
    assign w_diff      = w_pos_size - r_req;
    assign w_slack_sum = {1'b0, r_slack} + (LW+1)'(w_diff);
    assign w_used_sum  = {1'b0, r_used} + {1'b0, r_req};

    // Size registers take writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < nfpa_pkg::NUM_REGS; k++) begin
                r_size[k] <= (k == 0) ? nfpa_pkg::SIZE0_RST : '0;
            end
        end else if (i_cfg_valid &&
                     i_cfg_index < nfpa_pkg::CFG_IDX_W'(nfpa_pkg::NUM_REGS)) begin
            r_size[i_cfg_index[nfpa_pkg::REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // Ring of partition cells, token passes from cell i-1 to cell i
    for (genvar g = 0; g < NUM_PARTS; g++) begin : g_cell
        if (g < nfpa_pkg::NUM_REGS) begin : g_sized
            assign w_cell_size[g] = r_size[g];
        end else begin : g_unsized
            assign w_cell_size[g] = '0;
        end

        nfpa_cell #(
            .P_RST_OCC  (g == 0),
            .P_RST_HELD ((g == 0) ? SW'(OS_RESERVE) : '0)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_start  (r_start == IW'(g)),
            .i_tok_in (w_tok[(g + NUM_PARTS - 1) % NUM_PARTS]),
            .i_free   (w_release && (w_fidx_idx == IW'(g))),
            .i_size   (w_cell_size[g]),
            .o_tok    (w_tok[g]),
            .o_hit    (w_hit[g]),
            .o_occ    (w_occ[g]),
            .o_held   (w_held[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_req        = r_req;
        n_fidx       = r_fidx;
        n_used       = r_used;
        n_slack      = r_slack;
        n_start      = r_start;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_part   = r_res_part;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_part   = r_out_part;
        n_out_used   = r_out_used;
        n_out_slack  = r_out_slack;
        w_ctl        = '0;
        w_ctl.req    = r_req;
        w_release    = 1'b0;

        // Drop the result once the sink takes it
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = nfpa_pkg::t_op'(s_axis_tuser);
                    n_req   = s_axis_tdata[SW-1:0];
                    n_fidx  = s_axis_tdata[SW +: nfpa_pkg::FIDX_W];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res_part = '0;
                if (r_op == nfpa_pkg::OP_ALLOC) begin
                    if (r_used >= SW'(MEM_TOTAL)) begin
                        n_res_status = nfpa_pkg::ST_MEM_FULL;
                        n_state      = S_DONE;
                    end else if (w_used_sum > (SW+1)'(MEM_TOTAL)) begin
                        n_res_status = nfpa_pkg::ST_EXCEEDS;
                        n_state      = S_DONE;
                    end else begin
                        // Launch the token at the rotating start
                        w_ctl.load = 1'b1;
                        n_pos      = r_start;
                        n_cnt      = '0;
                        n_state    = S_SCAN;
                    end
                end else begin
                    if (w_fidx_ok && w_occ[w_fidx_idx]) begin
                        w_release    = 1'b1;
                        n_used       = (r_used >= w_free_held) ? r_used - w_free_held : '0;
                        n_res_status = nfpa_pkg::ST_FREED;
                        n_res_part   = r_fidx;
                    end else begin
                        n_res_status = nfpa_pkg::ST_INVALID;
                    end
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (|w_hit) begin
                    w_ctl.commit = 1'b1;
                    n_used       = w_used_sum[SW-1:0];
                    n_slack      = w_slack_sum[LW] ? '1 : w_slack_sum[LW-1:0];
                    n_start      = r_pos;
                    n_res_status = nfpa_pkg::ST_ALLOCATED;
                    n_res_part   = w_pos_ext[nfpa_pkg::PART_W-1:0];
                    n_state      = S_DONE;
                end else if (r_cnt == IW'(NUM_PARTS - 1)) begin
                    // One full lap without a fit
                    n_res_status = nfpa_pkg::ST_NO_FIT;
                    n_res_part   = '0;
                    n_state      = S_DONE;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_pos       = (r_pos == IW'(NUM_PARTS - 1)) ? '0 : r_pos + 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_part   = r_res_part;
                    n_out_used   = r_used;
                    n_out_slack  = r_slack;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= SW'(OS_RESERVE);
            r_slack     <= '0;
            r_start     <= IW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_slack     <= n_slack;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_req        <= n_req;
        r_fidx       <= n_fidx;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_part   <= n_res_part;
        r_out_status <= n_out_status;
        r_out_part   <= n_out_part;
        r_out_used   <= n_out_used;
        r_out_slack  <= n_out_slack;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_slack, r_out_used, r_out_part};

    `NFPA_ASSERT(a_tok_onehot0, $onehot0(w_tok), "more than one search token in the ring")
    `NFPA_ASSERT(a_scan_tok, (r_state == S_SCAN) |-> $onehot(w_tok), "scan without a single token")
    `NFPA_ASSERT(a_commit_hit, w_ctl.commit |-> $onehot(w_hit), "commit without exactly one hit")
    `NFPA_ASSERT(a_accept_check, (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CHECK), "transfer did not start a check")
    `NFPA_ASSERT(a_slack_mono, 1'b1 |=> (r_slack >= $past(r_slack)), "fragmentation sum went down")

endmodule

// File: bench/next_fit_partition_allocator_tb.sv
// Self-checking bench for the next-fit partition allocator: directed table, then random phases
`timescale 1ns / 1ps

module next_fit_partition_allocator_tb;

    localparam int NUM_PARTS   = nfpa_pkg::NUM_PARTS_DEF;
    localparam int MEM_TOTAL   = nfpa_pkg::MEM_TOTAL_DEF;
    localparam int OS_RESERVE  = nfpa_pkg::OS_RESERVE_DEF;
    localparam int NUM_REGS    = nfpa_pkg::NUM_REGS;
    localparam int SIZE_W      = nfpa_pkg::SIZE_W;
    localparam int SLACK_W     = nfpa_pkg::SLACK_W;
    localparam int PART_W      = nfpa_pkg::PART_W;
    localparam int FIDX_W      = nfpa_pkg::FIDX_W;
    localparam int CFG_IDX_W   = nfpa_pkg::CFG_IDX_W;
    localparam int STATUS_W    = nfpa_pkg::STATUS_W;
    localparam int IN_DATA_W   = nfpa_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = nfpa_pkg::OUT_DATA_W;
    localparam int SLACK_MAX   = (1 << SLACK_W) - 1;
    localparam int STALL_LIMIT = 2000;   // cycles without any transfer
    localparam int SETTLE      = 16;     // longest search plus pipeline, rounded up
    localparam int LONG_HOLD   = 150;    // receiver hold-off that backs up the block
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 48;

    // Register map of the size registers, plus the unmapped upper range
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE_PART0 = 4'd0,
        REG_SIZE_PART1 = 4'd1,
        REG_SIZE_PART2 = 4'd2,
        REG_SIZE_PART3 = 4'd3,
        REG_SIZE_PART4 = 4'd4,
        REG_SIZE_PART5 = 4'd5,
        REG_SIZE_PART6 = 4'd6,
        REG_SIZE_PART7 = 4'd7,
        REG_SPARE_LO   = 4'd8,
        REG_SPARE_HI   = 4'd15
    } t_size_reg;

    typedef struct packed {
        nfpa_pkg::t_status  status;
        logic [PART_W-1:0]  part;
        logic [SIZE_W-1:0]  used;
        logic [SLACK_W-1:0] slack;
    } t_alloc_result;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        nfpa_pkg::t_op        op;
        logic [SIZE_W-1:0]    req;
        logic [FIDX_W-1:0]    fidx;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SIZE_W-1:0]    reg_val;
        logic                 pinned;
        t_alloc_result        want;
    } t_stim_row;

    // DUT ports; every input starts at a known value
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // request_size, free_index, pad
    logic                  s_axis_tuser = 1'b0; // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // partition, used_total, slack_total, pad
    logic [STATUS_W-1:0]   m_axis_tuser;        // status
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [SIZE_W-1:0]     i_cfg_data = '0;

    // Side band that travels with each request: a hand-written expectation, if any
    logic          req_pinned = 1'b0;
    t_alloc_result req_want = '0;

    // Allocator mirror
    logic [SIZE_W-1:0]  part_size [NUM_PARTS];
    logic               part_busy [NUM_PARTS];
    logic [SIZE_W-1:0]  part_held [NUM_PARTS];
    logic [SIZE_W-1:0]  used_units;
    logic [PART_W-1:0]  search_from;
    logic [SLACK_W-1:0] slack_units;

    t_alloc_result pending_results[$];
    int sent_count  = 0;
    int got_count   = 0;
    int fault_count = 0;
    bit send_burst  = 1'b0;

    next_fit_partition_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Load the state the block holds after reset
    initial begin
        for (int p = 0; p < NUM_PARTS; p++) begin
            part_size[p] = '0;
            part_busy[p] = 1'b0;
            part_held[p] = '0;
        end
        part_size[0] = nfpa_pkg::SIZE0_RST;
        part_busy[0] = 1'b1;
        part_held[0] = SIZE_W'(OS_RESERVE);
        used_units   = SIZE_W'(OS_RESERVE);
        search_from  = PART_W'(1);
        slack_units  = '0;
    end

    task automatic log_mismatch(input string what, input int seen, input int wanted);
        fault_count++;
        $display("mismatch on result %0d, %0s: got %0d, expected %0d",
                 got_count, what, seen, wanted);
    endtask

    // Serve one request against the mirror and return the result it must produce
    function automatic t_alloc_result serve_request(input nfpa_pkg::t_op op,
                                                    input logic [SIZE_W-1:0] req,
                                                    input logic [FIDX_W-1:0] fidx);
        t_alloc_result     res;
        logic [PART_W-1:0] idx;
        bit                found;
        int                slack_next;
        res.status = nfpa_pkg::ST_INVALID;
        res.part   = '0;
        found      = 1'b0;
        if (op == nfpa_pkg::OP_ALLOC) begin
            if (int'(used_units) >= MEM_TOTAL) begin
                res.status = nfpa_pkg::ST_MEM_FULL;
            end else if (int'(used_units) + int'(req) > MEM_TOTAL) begin
                res.status = nfpa_pkg::ST_EXCEEDS;
            end else begin
                // One lap round the ring from the rotating start; the 3-bit index wraps
                res.status = nfpa_pkg::ST_NO_FIT;
                idx = search_from;
                for (int n = 0; n < NUM_PARTS && !found; n++) begin
                    if (!part_busy[idx] && part_size[idx] >= req) begin
                        found          = 1'b1;
                        part_busy[idx] = 1'b1;
                        part_held[idx] = req;
                        used_units     = used_units + req;
                        slack_next     = int'(slack_units) + int'(part_size[idx]) - int'(req);
                        slack_units    = (slack_next > SLACK_MAX) ? SLACK_W'(SLACK_MAX)
                                                                  : SLACK_W'(slack_next);
                        search_from    = idx;
                        res.status     = nfpa_pkg::ST_ALLOCATED;
                        res.part       = idx;
                    end else begin
                        idx = idx + 1'b1;
                    end
                end
            end
        end else if (part_busy[fidx]) begin
            used_units      = (used_units >= part_held[fidx]) ? used_units - part_held[fidx]
                                                               : '0;
            part_busy[fidx] = 1'b0;
            part_held[fidx] = '0;
            res.status      = nfpa_pkg::ST_FREED;
            res.part        = fidx;
        end
        res.used  = used_units;
        res.slack = slack_units;
        return res;
    endfunction

    // Predict on every request transfer; a hand-written expectation takes precedence
    always @(posedge i_clk) begin : track_requests
        t_alloc_result res;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            res = serve_request(nfpa_pkg::t_op'(s_axis_tuser), s_axis_tdata[SIZE_W-1:0],
                                s_axis_tdata[SIZE_W +: FIDX_W]);
            pending_results.push_back(req_pinned ? req_want : res);
        end
    end

    // Mirror register writes; the upper index range is stored nowhere
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_SIZE_PART7)
            part_size[i_cfg_index[PART_W-1:0]] = i_cfg_data;
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_count++;
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected result, status", int'(m_axis_tuser), -1);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    log_mismatch("status", int'(m_axis_tuser), int'(want.status));
                if (m_axis_tdata[PART_W-1:0] !== want.part)
                    log_mismatch("partition", int'(m_axis_tdata[PART_W-1:0]), int'(want.part));
                if (m_axis_tdata[PART_W +: SIZE_W] !== want.used)
                    log_mismatch("used_total", int'(m_axis_tdata[PART_W +: SIZE_W]),
                                 int'(want.used));
                if (m_axis_tdata[PART_W + SIZE_W +: SLACK_W] !== want.slack)
                    log_mismatch("slack_total", int'(m_axis_tdata[PART_W + SIZE_W +: SLACK_W]),
                                 int'(want.slack));
            end
        end
    end

    // Receiver: random hold-offs, stretches without any, and one long hold-off that
    // backs the block up while the sender keeps offering requests
    initial begin : drain_results
        int  wait_cycles;
        int  draws;
        bit  burst;
        bit  held_long;
        draws     = 0;
        burst     = 1'b0;
        held_long = 1'b0;
        wait (i_rst_n);
        forever begin
            draws++;
            if (draws % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            wait_cycles = burst ? 0 : $urandom_range(0, 8);
            if (!held_long && got_count >= 150) begin
                held_long   = 1'b1;
                wait_cycles = LONG_HOLD;
            end
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog: end the run when nothing has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one request after a random gap; tvalid stays high for back-to-back transfers
    task automatic offer_request(input nfpa_pkg::t_op op, input logic [SIZE_W-1:0] req,
                                 input logic [FIDX_W-1:0] fidx, input logic pinned,
                                 input t_alloc_result want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, fidx, req};
        req_pinned    <= pinned;
        req_want      <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    // Drop tvalid, wait for every outstanding result, then let the block settle
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        wait (got_count == sent_count);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Hold valid until the write transfers; the caller drops it after the last one
    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic t_alloc_result want_of(input nfpa_pkg::t_status status,
                                              input logic [PART_W-1:0] part,
                                              input logic [SIZE_W-1:0] used,
                                              input logic [SLACK_W-1:0] slack);
        t_alloc_result r;
        r.status = status;
        r.part   = part;
        r.used   = used;
        r.slack  = slack;
        return r;
    endfunction

    function automatic t_stim_row item_row(input nfpa_pkg::t_op op,
                                           input logic [SIZE_W-1:0] req,
                                           input logic [FIDX_W-1:0] fidx);
        t_stim_row row;
        row        = '0;
        row.kind   = ROW_ITEM;
        row.op     = op;
        row.req    = req;
        row.fidx   = fidx;
        return row;
    endfunction

    function automatic t_stim_row pinned_row(input nfpa_pkg::t_op op,
                                             input logic [SIZE_W-1:0] req,
                                             input logic [FIDX_W-1:0] fidx,
                                             input t_alloc_result want);
        t_stim_row row;
        row        = item_row(op, req, fidx);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input t_size_reg idx, input logic [SIZE_W-1:0] value);
        t_stim_row row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = value;
        return row;
    endfunction

    // Partition size for a random phase; the phases sweep small, empty and full-scale maps
    function automatic logic [SIZE_W-1:0] size_for_phase(input int ph);
        case (ph)
            1, 7:    return '1;
            2:       return '0;
            3:       return SIZE_W'($urandom_range(0, 4095));
            4: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return '1;
                    default: return SIZE_W'($urandom_range(0, 500));
                endcase
            end
            5:       return SIZE_W'($urandom_range(0, 300));
            6:       return SIZE_W'($urandom_range(0, 1000));
            default: return SIZE_W'($urandom_range(0, 700));
        endcase
    endfunction

    // Draw one request: mostly allocations sized against the current map and frees of
    // held partitions, with a share of arbitrary sizes and frees of empty slots
    task automatic random_request(input int ph);
        int                busy_list[$];
        int                pick;
        logic [SIZE_W-1:0] req;
        logic [FIDX_W-1:0] fidx;
        logic [SIZE_W-1:0] ref_size;
        req      = SIZE_W'($urandom_range(0, 4095));
        fidx     = FIDX_W'($urandom_range(0, NUM_PARTS - 1));
        ref_size = part_size[$urandom_range(0, NUM_PARTS - 1)];
        if ($urandom_range(0, 99) < 55) begin
            pick = $urandom_range(0, 9);
            if (ph == 7 && $urandom_range(0, 1) == 0)
                req = '0;
            else if (pick == 2)
                req = '0;
            else if (pick == 3)
                req = '1;
            else if (pick >= 4 && pick <= 6)
                req = ref_size;
            else if (pick == 7)
                req = ref_size + 1'b1;
            else if (pick >= 8)
                req = SIZE_W'($urandom_range(0, int'(ref_size)));
            offer_request(nfpa_pkg::OP_ALLOC, req, fidx, 1'b0, '0);
        end else begin
            for (int p = 0; p < NUM_PARTS; p++)
                if (part_busy[p])
                    busy_list.push_back(p);
            if (busy_list.size() > 0 && $urandom_range(0, 3) != 0)
                fidx = FIDX_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            offer_request(nfpa_pkg::OP_FREE, req, fidx, 1'b0, '0);
        end
    endtask

    // Stimulus: reset, directed table, then random phases each behind a fresh size map
    initial begin : stimulus
        t_stim_row stim_rows[$];
        t_stim_row row;

        // Rows right after reset: only partition zero has a size, and it is taken
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_ALLOC, 12'd1, 3'd0,
                            want_of(nfpa_pkg::ST_NO_FIT, 3'd0, 12'd100, 16'd0)));
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_ALLOC, 12'd0, 3'd7,
                            want_of(nfpa_pkg::ST_ALLOCATED, 3'd1, 12'd100, 16'd0)));
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_ALLOC, 12'd4095, 3'd0,
                            want_of(nfpa_pkg::ST_EXCEEDS, 3'd0, 12'd100, 16'd0)));
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_FREE, 12'd4095, 3'd1,
                            want_of(nfpa_pkg::ST_FREED, 3'd1, 12'd100, 16'd0)));
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_FREE, 12'd0, 3'd1,
                            want_of(nfpa_pkg::ST_INVALID, 3'd0, 12'd100, 16'd0)));
        // Release the system reservation itself
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_FREE, 12'd0, 3'd0,
                            want_of(nfpa_pkg::ST_FREED, 3'd0, 12'd0, 16'd0)));
        // New map: full-scale partition one, extremes in the others, unmapped write
        stim_rows.push_back(cfg_row(REG_SIZE_PART0, 12'd0));
        stim_rows.push_back(cfg_row(REG_SIZE_PART1, 12'd4095));
        stim_rows.push_back(cfg_row(REG_SIZE_PART2, 12'd1900));
        stim_rows.push_back(cfg_row(REG_SIZE_PART3, 12'd100));
        stim_rows.push_back(cfg_row(REG_SIZE_PART7, 12'd7));
        stim_rows.push_back(cfg_row(REG_SPARE_HI, 12'd4095));
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd1900, 3'd0));
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd100, 3'd0));
        // Used memory now sits exactly at the total
        stim_rows.push_back(pinned_row(nfpa_pkg::OP_ALLOC, 12'd1, 3'd7,
                            want_of(nfpa_pkg::ST_MEM_FULL, 3'd0, 12'd2000, 16'd3995)));
        stim_rows.push_back(item_row(nfpa_pkg::OP_FREE, 12'd0, 3'd1));
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd4095, 3'd0));
        // Search wraps past the end of the ring back to partition one
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd1900, 3'd0));
        stim_rows.push_back(item_row(nfpa_pkg::OP_FREE, 12'd0, 3'd2));
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd0, 3'd0));
        stim_rows.push_back(item_row(nfpa_pkg::OP_FREE, 12'd0, 3'd7));
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd100, 3'd0));
        stim_rows.push_back(item_row(nfpa_pkg::OP_FREE, 12'd0, 3'd0));
        stim_rows.push_back(item_row(nfpa_pkg::OP_FREE, 12'd0, 3'd3));
        stim_rows.push_back(item_row(nfpa_pkg::OP_ALLOC, 12'd7, 3'd0));

        // Hold reset, then release it once and for good
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.kind == ROW_CFG) begin
                quiesce();
                write_size_reg(row.reg_idx, row.reg_val);
                i_cfg_valid <= 1'b0;
            end else begin
                offer_request(row.op, row.req, row.fidx, row.pinned, row.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            for (int r = 0; r < NUM_REGS; r++)
                write_size_reg(REG_SIZE_PART0 + CFG_IDX_W'(r), size_for_phase(ph));
            if (ph == 3 || ph == 6)
                write_size_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                               SIZE_W'($urandom_range(0, 4095)));
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 16 == 0)
                    send_burst = ($urandom_range(0, 3) == 0);
                // Pause mid-phase until the block has handed back everything
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    quiesce();
                random_request(ph);
            end
        end

        quiesce();
        if (pending_results.size() != 0)
            log_mismatch("results never delivered", pending_results.size(), 0);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
